/* hdl/erlpd_pkg.sv */
// shared types and constants for the escape run-length prefixed deframer
// no dependencies; used by the interfaces and every module in hdl
package erlpd_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned LengthWidth   = 32;
   localparam int unsigned HeaderBytes   = 4;
   localparam int unsigned HdrCountWidth = 2;
   localparam logic [HdrCountWidth-1:0] HdrLastIdx = HdrCountWidth'(HeaderBytes - 1);
   localparam logic [ByteWidth-1:0] EscapeReset = '0;

   typedef logic [ByteWidth-1:0]     byte_type;
   typedef logic [LengthWidth-1:0]   length_type;
   typedef logic [HdrCountWidth-1:0] hdr_count_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // one decoded result word
   typedef struct packed {
      byte_type out_byte;
      logic     byte_valid;
      logic     frame_end;
      logic     marker_error;
   } rsp_word_type;

   // parser outcome for the word held in the input register
   typedef struct packed {
      logic         has_result;
      rsp_word_type word;
   } parse_type;

endpackage

/* hdl/erlpd_ifs.sv */
// valid/ready channel interfaces for the deframer request and response sides
// depends on erlpd_pkg
interface erlpd_req_if;
   logic                valid;
   logic                ready;
   erlpd_pkg::byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface erlpd_rsp_if;
   logic                valid;
   logic                ready;
   erlpd_pkg::byte_type out_byte;
   logic                byte_valid;
   logic                frame_end;
   logic                marker_error;

   modport source (output valid, output out_byte, output byte_valid, output frame_end,
                   output marker_error, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                   input marker_error, output ready);
endinterface

/* hdl/erlpd_in_reg.sv */
// input register of the deframer: captures one stream word per accept
// depends on erlpd_pkg and erlpd_req_if
module erlpd_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   erlpd_req_if.sink            req,
   input  logic                 advance,
   output logic                 held_valid,
   output erlpd_pkg::byte_type  held_byte
);

   logic                valid_ff;
   logic                valid_in;
   erlpd_pkg::byte_type byte_ff;
   logic                take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req.in_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

/* hdl/erlpd_parser.sv */
// frame parser: hunt, length header and payload unstuffing state
// depends on erlpd_pkg
module erlpd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  erlpd_pkg::byte_type  escape_byte,
   input  erlpd_pkg::byte_type  cur_byte,
   input  logic                 advance,
   output erlpd_pkg::parse_type parse
);

   erlpd_pkg::phase_type     phase_ff,  phase_in;
   erlpd_pkg::hdr_count_type hdr_ff,    hdr_in;
   erlpd_pkg::length_type    remain_ff, remain_in;
   logic                     run_ff,    run_in;
   logic                     any_ff,    any_in;

   erlpd_pkg::length_type    remain_dec;
   erlpd_pkg::length_type    remain_hdr;
   logic                     is_escape;
   logic                     last_byte;
   logic                     drop;

   assign remain_dec = remain_ff - erlpd_pkg::LengthWidth'(1);
   assign remain_hdr = {remain_ff[erlpd_pkg::LengthWidth-erlpd_pkg::ByteWidth-1:0], cur_byte};
   assign is_escape  = (cur_byte == escape_byte);
   assign last_byte  = (remain_dec == '0);
   // first escape of a run is the stuffing byte
   assign drop       = is_escape && !run_ff;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      remain_in = remain_ff;
      run_in    = run_ff;
      any_in    = any_ff;
      case (phase_ff)
         erlpd_pkg::PH_HEADER: begin
            remain_in = remain_hdr;
            if (hdr_ff == erlpd_pkg::HdrLastIdx) begin
               hdr_in   = '0;
               phase_in = (remain_hdr == '0) ? erlpd_pkg::PH_HUNT : erlpd_pkg::PH_PAYLOAD;
            end else begin
               hdr_in = hdr_ff + erlpd_pkg::HdrCountWidth'(1);
            end
         end
         erlpd_pkg::PH_PAYLOAD: begin
            remain_in = remain_dec;
            run_in    = is_escape;
            if (last_byte) begin
               phase_in = erlpd_pkg::PH_HUNT;
            end
            if (!drop) begin
               any_in = 1'b1;
            end
         end
         default: begin
            if (is_escape) begin
               phase_in  = erlpd_pkg::PH_HEADER;
               hdr_in    = '0;
               remain_in = '0;
               run_in    = 1'b0;
               any_in    = 1'b0;
            end else begin
               phase_in = erlpd_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      parse = '0;
      case (phase_ff)
         erlpd_pkg::PH_HEADER: begin
            parse.has_result = 1'b0;
         end
         erlpd_pkg::PH_PAYLOAD: begin
            if (!drop) begin
               parse.has_result      = 1'b1;
               parse.word.out_byte   = cur_byte;
               parse.word.byte_valid = 1'b1;
               parse.word.frame_end  = last_byte;
            end else if (last_byte && any_ff) begin
               parse.has_result     = 1'b1;
               parse.word.frame_end = 1'b1;
            end
         end
         default: begin
            if (!is_escape) begin
               parse.has_result        = 1'b1;
               parse.word.marker_error = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= erlpd_pkg::PH_HUNT;
         hdr_ff    <= '0;
         remain_ff <= '0;
         run_ff    <= 1'b0;
         any_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         hdr_ff    <= hdr_in;
         remain_ff <= remain_in;
         run_ff    <= run_in;
         any_ff    <= any_in;
      end
   end

endmodule

/* hdl/erlpd_out_reg.sv */
// result register of the deframer: holds one word until the sink takes it
// depends on erlpd_pkg and erlpd_rsp_if
module erlpd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  erlpd_pkg::rsp_word_type word,
   erlpd_rsp_if.source             rsp
);

   logic                    valid_ff;
   logic                    valid_in;
   erlpd_pkg::rsp_word_type word_ff;

   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_byte     = word_ff.out_byte;
   assign rsp.byte_valid   = word_ff.byte_valid;
   assign rsp.frame_end    = word_ff.frame_end;
   assign rsp.marker_error = word_ff.marker_error;

endmodule

/* hdl/escape_run_length_prefixed_deframer.sv */
// deframer for escape-stuffed, length-prefixed frames: one stream word in, at most one out
// a stream word is registered in the input register, its result word in the result register
// throughput: one word per cycle without stalls; the input register frees whenever the
// result register drains or the word gives no result, so rsp_chan.ready gates req_chan.ready
// reset: synchronous, active high; clears both stage valids, parser state and escape value
// depends on erlpd_pkg, erlpd_ifs, erlpd_in_reg, erlpd_parser and erlpd_out_reg
module escape_run_length_prefixed_deframer (
   input  logic                clock,
   input  logic                reset,
   erlpd_req_if.sink           req_chan,
   erlpd_rsp_if.source         rsp_chan,
   input  logic                csr_wr_en,
   input  erlpd_pkg::byte_type csr_wr_data
);

   // escape / marker value register
   erlpd_pkg::byte_type escape_ff;

   // word sitting in the input register
   logic                 held_valid;
   erlpd_pkg::byte_type  held_byte;

   // parser outcome for that word
   erlpd_pkg::parse_type parse;

   // word leaves the input register this cycle and parser state steps
   logic advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= erlpd_pkg::EscapeReset;
      end else if (csr_wr_en) begin
         escape_ff <= csr_wr_data;
      end
   end

   // a word with no result always moves on; one with a result needs room downstream
   assign advance = held_valid &&
                    (!parse.has_result || !rsp_chan.valid || rsp_chan.ready);

   erlpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   erlpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .escape_byte (escape_ff),
      .cur_byte    (held_byte),
      .advance     (advance),
      .parse       (parse)
   );

   erlpd_out_reg u_out_reg (
      .clock (clock),
      .reset (reset),
      .load  (advance && parse.has_result),
      .word  (parse.word),
      .rsp   (rsp_chan)
   );

`ifndef SYNTHESIS
   // a marker error word carries nothing else
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.marker_error |->
         !rsp_chan.byte_valid && !rsp_chan.frame_end && (rsp_chan.out_byte == '0))
      else $error("marker error word carries payload flags");

   // a word without payload is either a marker error or a bare frame end
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.byte_valid |->
         (rsp_chan.marker_error || rsp_chan.frame_end) && (rsp_chan.out_byte == '0))
      else $error("empty result word is neither error nor frame end");

   // a held word that cannot move blocks new words
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      held_valid && !advance |-> !req_chan.ready)
      else $error("input register overwritten while stalled");

   // nothing is offered on the first edge after reset is released
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_chan.valid)
      else $error("result offered right after reset");
`endif

endmodule

/* tb/sv/escape_run_length_prefixed_deframer_test.sv */
// self-checking testbench for escape_run_length_prefixed_deframer: drives framed byte
// streams and predicts every decoded word; depends on erlpd_pkg and erlpd_ifs from hdl
module escape_run_length_prefixed_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;

   // generous bound on the whole run, enforced by the watchdog
   localparam int unsigned CycleLimit  = 200000;
   // pipeline is two deep, so a word giving no result is gone well within this
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned EscapePct   = 35;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   erlpd_pkg::byte_type csr_wr_data = '0;

   erlpd_req_if req_chan();
   erlpd_rsp_if rsp_chan();

   escape_run_length_prefixed_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // idling odds in percent per cycle, and a long receiver hold-off on request
   int unsigned tx_idle_pct  = 0;
   int unsigned rx_idle_pct  = 0;
   int unsigned hold_request = 0;

   int unsigned words_sent  = 0;
   int unsigned errors      = 0;
   int unsigned cycle_count = 0;

   // decoder state mirrored on the testbench side
   erlpd_pkg::byte_type      esc_value     = erlpd_pkg::EscapeReset;
   erlpd_pkg::phase_type     parse_phase   = erlpd_pkg::PH_HUNT;
   erlpd_pkg::hdr_count_type hdr_taken     = '0;
   erlpd_pkg::length_type    len_left      = '0;
   logic                     in_run        = 1'b0;
   logic                     frame_emitted = 1'b0;

   // decoded words still owed by the block, oldest first
   erlpd_pkg::rsp_word_type pending_words[$];

   // append one word to the owed list
   function automatic void owe_word(erlpd_pkg::rsp_word_type w);
      pending_words = {pending_words, w};
   endfunction

   // work out what one accepted stream word should give
   function automatic void deframe_predict(erlpd_pkg::byte_type b);
      logic                    last_byte;
      logic                    dropped;
      erlpd_pkg::rsp_word_type w;
      case (parse_phase)
         erlpd_pkg::PH_HEADER: begin
            // length bytes are taken raw, big-endian, even when equal to the escape
            len_left = {len_left[erlpd_pkg::LengthWidth-erlpd_pkg::ByteWidth-1:0], b};
            if (hdr_taken == erlpd_pkg::HdrLastIdx) begin
               hdr_taken   = '0;
               parse_phase = (len_left == '0) ? erlpd_pkg::PH_HUNT : erlpd_pkg::PH_PAYLOAD;
            end else begin
               hdr_taken = hdr_taken + erlpd_pkg::HdrCountWidth'(1);
            end
         end
         erlpd_pkg::PH_PAYLOAD: begin
            len_left  = len_left - erlpd_pkg::LengthWidth'(1);
            last_byte = (len_left == '0);
            dropped   = 1'b0;
            // only the first escape of a run is stripped
            if (b == esc_value) begin
               dropped = !in_run;
               in_run  = 1'b1;
            end else begin
               in_run = 1'b0;
            end
            if (last_byte)
               parse_phase = erlpd_pkg::PH_HUNT;
            if (!dropped) begin
               frame_emitted = 1'b1;
               w = '{b, 1'b1, last_byte, 1'b0};
               owe_word(w);
            end else if (last_byte && frame_emitted) begin
               // dropped closing byte still has to close the frame
               w = '{8'h00, 1'b0, 1'b1, 1'b0};
               owe_word(w);
            end
         end
         default: begin
            // hunting for the marker
            if (b == esc_value) begin
               parse_phase   = erlpd_pkg::PH_HEADER;
               hdr_taken     = '0;
               len_left      = '0;
               in_run        = 1'b0;
               frame_emitted = 1'b0;
            end else begin
               parse_phase = erlpd_pkg::PH_HUNT;
               w = '{8'h00, 1'b0, 1'b0, 1'b1};
               owe_word(w);
            end
         end
      endcase
   endfunction

   function automatic erlpd_pkg::byte_type non_escape_byte();
      erlpd_pkg::byte_type v;
      do v = erlpd_pkg::byte_type'($urandom); while (v == esc_value);
      return v;
   endfunction

   function automatic erlpd_pkg::byte_type payload_byte();
      // lean heavily on the escape value so runs of every length turn up
      if ($urandom_range(99) < EscapePct)
         return esc_value;
      return erlpd_pkg::byte_type'($urandom);
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   // offer one stream word, with random idle cycles ahead of it, until accepted
   task automatic send_word(erlpd_pkg::byte_type b);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= erlpd_pkg::byte_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      deframe_predict(b);
      words_sent++;
   endtask

   // marker, four length bytes, then the escaped body as given
   task automatic send_frame(erlpd_pkg::length_type claimed,
                             input erlpd_pkg::byte_type body[$]);
      send_word(esc_value);
      for (int i = 3; i >= 0; i--)
         send_word(claimed[8*i +: 8]);
      foreach (body[i])
         send_word(body[i]);
   endtask

   // stop offering, wait out every owed word, then let the pipeline empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_escape(erlpd_pkg::byte_type value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      esc_value = value;
      csr_wr_en <= 1'b0;
   endtask

   // one frame with random shape, or a few stray bytes between frames
   task automatic random_frame();
      erlpd_pkg::byte_type body[$];
      int unsigned         pick;
      int unsigned         len;
      pick = $urandom_range(99);
      if (pick < 6) begin
         // stray bytes while hunting, each one a marker error
         repeat ($urandom_range(3, 1)) send_word(non_escape_byte());
         return;
      end
      if (pick < 12)
         len = 0;
      else if (pick < 20)
         len = $urandom_range(40, 9);
      else
         len = $urandom_range(8, 1);
      repeat (len) body = {body, payload_byte()};
      send_frame(len, body);
      // trailing junk after a frame, as if the length were short
      if (pick >= 94)
         repeat ($urandom_range(3, 1)) send_word(non_escape_byte());
   endtask

   // hand-picked cases under the reset escape value, then the top escape value
   task automatic test_directed();
      erlpd_pkg::byte_type body[$];
      send_word(8'hFF);
      send_word(8'h5A);
      // zero length: header only, nothing decoded
      body = {};
      send_frame(0, body);
      // escape runs: first of each run dropped, rest passed
      body = {8'h00, 8'h00, 8'hAB, 8'h00, 8'hFF};
      send_frame(5, body);
      // closing byte dropped after something was emitted: bare frame end
      body = {8'h12, 8'h00};
      send_frame(2, body);
      // frame that decodes to nothing at all
      body = {8'h00};
      send_frame(1, body);
      set_escape(8'hFF);
      body = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
      send_frame(5, body);
      settle();
   endtask

   task automatic test_random_frames(int unsigned tx_pct, int unsigned rx_pct,
                                     erlpd_pkg::byte_type esc, int unsigned count);
      int unsigned goal;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      set_escape(esc);
      goal = words_sent + count;
      while (words_sent < goal)
         random_frame();
      settle();
   endtask

   // receiver holds off for a long stretch while a long frame keeps coming
   task automatic test_backpressure();
      erlpd_pkg::byte_type body[$];
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_escape(8'h55);
      repeat (32) body = {body, non_escape_byte()};
      hold_request = 200;
      send_frame(32, body);
      settle();
   endtask

   // all-ones length never completes, so this has to be the last stimulus
   task automatic test_endless_frame();
      erlpd_pkg::byte_type body[$];
      set_escape(8'hFF);
      repeat (40) body = {body, payload_byte()};
      send_frame(32'hFFFF_FFFF, body);
      settle();
   endtask

   // ready driver with its own hold-off counter
   initial begin : drive_ready
      int unsigned hold_left;
      hold_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // every accepted result word against the oldest owed one
   always @(posedge clock) begin : check_words
      erlpd_pkg::rsp_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %0h/%0b/%0b/%0b", $time,
                     rsp_chan.out_byte, rsp_chan.byte_valid, rsp_chan.frame_end,
                     rsp_chan.marker_error);
            errors++;
         end else begin
            want = pending_words.pop_front();
            compare_field("out_byte", want.out_byte, rsp_chan.out_byte);
            compare_field("byte_valid", 8'(want.byte_valid), 8'(rsp_chan.byte_valid));
            compare_field("frame_end", 8'(want.frame_end), 8'(rsp_chan.frame_end));
            compare_field("marker_error", 8'(want.marker_error),
                          8'(rsp_chan.marker_error));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : run_tests
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender light, receiver heavy idling
      tx_idle_pct = 23;
      rx_idle_pct = 70;
      test_directed();
      test_random_frames(23, 70, 8'h7E, 300);
      // the other way round, with the bottom escape value written explicitly
      test_random_frames(70, 23, 8'h00, 300);
      // no idling, arbitrary escape value
      test_random_frames(0, 0, erlpd_pkg::byte_type'($urandom), 300);
      test_backpressure();
      test_endless_frame();

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
hdl/erlpd_pkg.sv
hdl/erlpd_ifs.sv
hdl/erlpd_in_reg.sv
hdl/erlpd_parser.sv
hdl/erlpd_out_reg.sv
hdl/escape_run_length_prefixed_deframer.sv
tb/sv/escape_run_length_prefixed_deframer_test.sv
